// ===== rtl/core/rdd_pkg.sv =====
// Package for the resource deadlock detector: sizes, action and state codes,
// RAM port and result structs, count saturation helpers. No dependencies.
package rdd_pkg;

   localparam int MAX_PROCS   = 16;
   localparam int MAX_SEMS    = 16;
   localparam int COUNT_BITS  = 16;

   localparam int ACTION_BITS = 4;
   localparam int SLOT_BITS   = 4;
   localparam int INIT_BITS   = 16;
   localparam int ID_BITS     = 16;

   localparam int PROC_BITS   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int SEM_BITS    = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
   localparam int ADDR_BITS   = PROC_BITS + SEM_BITS;
   localparam int RAM_DEPTH   = 1 << ADDR_BITS;
   localparam int ENTRY_BITS  = 2 * COUNT_BITS;
   localparam int SWEEP_BITS  = ADDR_BITS + 1;
   localparam int SUM_BITS    = ((COUNT_BITS > INIT_BITS) ? COUNT_BITS : INIT_BITS) + 2;
   localparam int WORK_BITS   = COUNT_BITS + PROC_BITS + 2;

   localparam logic signed [SUM_BITS-1:0] S_MAX =
      {{(SUM_BITS-COUNT_BITS+1){1'b0}}, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] S_MIN = ~S_MAX;
   localparam logic signed [SUM_BITS-1:0] U_MAX =
      {{(SUM_BITS-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_SEM_CREATE    = 4'd0,
      ACT_INSTANT_GRANT = 4'd1,
      ACT_WAIT_GRANT    = 4'd2,
      ACT_REQUEST       = 4'd3,
      ACT_RELEASE       = 4'd4,
      ACT_SEM_DESTROY   = 4'd5,
      ACT_PROC_CREATE   = 4'd6,
      ACT_PROC_TERM     = 4'd7,
      ACT_DETECT        = 4'd8
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RMW,
      ST_CLR_COL,
      ST_CLR_ROW,
      ST_INIT,
      ST_PASS,
      ST_FIT,
      ST_ADD,
      ST_VSCAN,
      ST_FREE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_BITS-1:0]  waddr;
      logic [ENTRY_BITS-1:0] wdata;
      logic [ADDR_BITS-1:0]  raddr;
   } ram_req_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] slot;
      logic [ID_BITS-1:0]   id;
   } result_type;

   function automatic logic signed [COUNT_BITS-1:0] sat_signed(
      input logic signed [SUM_BITS-1:0] v);
      if (v > S_MAX) begin
         return S_MAX[COUNT_BITS-1:0];
      end else if (v < S_MIN) begin
         return S_MIN[COUNT_BITS-1:0];
      end
      return v[COUNT_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_unsigned(
      input logic signed [SUM_BITS-1:0] v);
      if (v > U_MAX) begin
         return U_MAX[COUNT_BITS-1:0];
      end else if (v < 0) begin
         return '0;
      end
      return v[COUNT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/resource_deadlock_detector.sv =====
// Resource deadlock detector top level: stream ports, result register,
// held/wanted RAM. Depends on rdd_pkg, rdd_ram and rdd_ctrl.
//
// One request beat is taken at a time and gives exactly one response beat.
// Request, grant and release beats go through dispatch with the RAM read,
// modify and write back, hand-off to the output register, and the idle
// state that takes the next beat. Destroy, terminate and unused actions go
// from dispatch straight to the hand-off. Semaphore and process create add
// a clearing sweep of the held/wanted RAM column or row. Detect walks the
// RAM: a sweep of all entries marks idle processes, then each pass reads
// the row of every unfinished process checked and, if it fits, reads it
// again to add its holdings, passes repeating until nothing changes, then
// a victim scan and a sweep to free the victim. The RAM's single read port
// makes these sweeps serial. A response waiting in the output register does
// not block the next request from being taken, but that request's result
// waits for hand-off until the output register is free.
module resource_deadlock_detector
   import rdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // proc_slot, sem_slot, sem_initial, proc_id
   input  logic [3:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // victim_slot, victim_id, zero fill
   output logic [0:0]  rsp_tuser    // deadlock_found
);

   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   logic                  in_ready;
   logic                  res_valid;
   result_type            res;
   ram_req_type           ram_req;
   logic [ENTRY_BITS-1:0] ram_rdata;
   logic                  rsp_free;

   assign req_tready = in_ready && !reset;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   rdd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid && req_tready),
      .in_ready    (in_ready),
      .action      (req_tuser),
      .proc_slot   (req_tdata[3:0]),
      .sem_slot    (req_tdata[7:4]),
      .sem_initial ($signed(req_tdata[23:8])),
      .proc_id     (req_tdata[39:24]),
      .rsp_free    (rsp_free),
      .res_valid   (res_valid),
      .res         (res),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata)
   );

   rdd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {4'b0, rsp_ff.id, rsp_ff.slot};

endmodule

// ===== rtl/core/rdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/rdd_ctrl.sv =====
// Event sequencer of the deadlock detector: slot tables, count updates and
// the detection passes over the held/wanted RAM. Depends on rdd_pkg.
module rdd_ctrl
   import rdd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ACTION_BITS-1:0]        action,
   input  logic [SLOT_BITS-1:0]          proc_slot,
   input  logic [SLOT_BITS-1:0]          sem_slot,
   input  logic signed [INIT_BITS-1:0]   sem_initial,
   input  logic [ID_BITS-1:0]            proc_id,
   input  logic                          rsp_free,
   output logic                          res_valid,
   output result_type                    res,
   output ram_req_type                   ram_req,
   input  logic [ENTRY_BITS-1:0]         ram_rdata
);

   state_type                      state_ff, state_in;
   logic [ACTION_BITS-1:0]         action_ff, action_in;
   logic [PROC_BITS-1:0]           pidx_ff, pidx_in;
   logic [SEM_BITS-1:0]            sidx_ff, sidx_in;
   logic                           pok_ff, pok_in;
   logic                           sok_ff, sok_in;
   logic signed [INIT_BITS-1:0]    init_ff, init_in;
   logic [ID_BITS-1:0]             id_ff, id_in;

   logic signed [COUNT_BITS-1:0]   avail_ff [MAX_SEMS];
   logic signed [COUNT_BITS-1:0]   avail_in [MAX_SEMS];
   logic signed [WORK_BITS-1:0]    work_ff [MAX_SEMS];
   logic signed [WORK_BITS-1:0]    work_in [MAX_SEMS];
   logic [ID_BITS-1:0]             ident_ff [MAX_PROCS];
   logic [ID_BITS-1:0]             ident_in [MAX_PROCS];
   logic [MAX_PROCS-1:0]           pvalid_ff, pvalid_in;
   logic [MAX_SEMS-1:0]            svalid_ff, svalid_in;
   logic [MAX_PROCS-1:0]           done_ff, done_in;

   logic [SWEEP_BITS-1:0]          iss_ff, iss_in;
   logic                           rd_v_ff, rd_v_in;
   logic [SWEEP_BITS-1:0]          rd_idx_ff, rd_idx_in;
   logic [PROC_BITS:0]             cur_p_ff, cur_p_in;
   logic                           changed_ff, changed_in;
   logic                           fits_ff, fits_in;
   logic                           found_ff, found_in;
   logic [PROC_BITS-1:0]           victim_ff, victim_in;
   result_type                     res_ff, res_in;

   logic [SWEEP_BITS-1:0]          limit;
   logic                           iss_more;
   logic                           sweep_end;
   logic                           sweep_rd;
   logic [COUNT_BITS-1:0]          held;
   logic [COUNT_BITS-1:0]          wanted;
   logic [COUNT_BITS-1:0]          held_n;
   logic [COUNT_BITS-1:0]          wanted_n;
   logic [SEM_BITS-1:0]            d_s;
   logic [PROC_BITS-1:0]           d_p;
   logic [PROC_BITS-1:0]           cp;
   logic                           both;
   logic signed [SUM_BITS-1:0]     a_x, h_x, w_x;

   assign in_ready = (state_ff == ST_IDLE);
   assign res      = res_ff;
   assign held     = ram_rdata[ENTRY_BITS-1:COUNT_BITS];
   assign wanted   = ram_rdata[COUNT_BITS-1:0];
   assign d_s      = rd_idx_ff[SEM_BITS-1:0];
   assign d_p      = rd_idx_ff[ADDR_BITS-1:SEM_BITS];
   assign cp       = cur_p_ff[PROC_BITS-1:0];
   assign both     = pok_ff && sok_ff && pvalid_ff[pidx_ff] && svalid_ff[sidx_ff];
   assign a_x      = SUM_BITS'(avail_ff[sidx_ff]);
   assign h_x      = $signed(SUM_BITS'(held));
   assign w_x      = $signed(SUM_BITS'(wanted));

   always_comb begin
      unique case (state_ff)
         ST_INIT:    limit = SWEEP_BITS'(RAM_DEPTH);
         ST_CLR_COL: limit = SWEEP_BITS'(MAX_PROCS);
         default:    limit = SWEEP_BITS'(MAX_SEMS);
      endcase
   end

   assign iss_more  = iss_ff < limit;
   assign sweep_end = !iss_more && !rd_v_ff;
   assign sweep_rd  = (state_ff == ST_INIT) || (state_ff == ST_FIT) ||
                      (state_ff == ST_ADD) || (state_ff == ST_FREE);

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      pidx_in    = pidx_ff;
      sidx_in    = sidx_ff;
      pok_in     = pok_ff;
      sok_in     = sok_ff;
      init_in    = init_ff;
      id_in      = id_ff;
      avail_in   = avail_ff;
      work_in    = work_ff;
      ident_in   = ident_ff;
      pvalid_in  = pvalid_ff;
      svalid_in  = svalid_ff;
      done_in    = done_ff;
      iss_in     = iss_ff;
      rd_v_in    = 1'b0;
      rd_idx_in  = iss_ff;
      cur_p_in   = cur_p_ff;
      changed_in = changed_ff;
      fits_in    = fits_ff;
      found_in   = found_ff;
      victim_in  = victim_ff;
      res_in     = res_ff;
      res_valid  = 1'b0;
      held_n     = held;
      wanted_n   = wanted;

      ram_req.we    = 1'b0;
      ram_req.waddr = {pidx_ff, sidx_ff};
      ram_req.wdata = '0;
      ram_req.raddr = {pidx_ff, sidx_ff};

      unique case (state_ff)
         ST_INIT:        ram_req.raddr = iss_ff[ADDR_BITS-1:0];
         ST_FIT, ST_ADD: ram_req.raddr = {cp, iss_ff[SEM_BITS-1:0]};
         ST_FREE:        ram_req.raddr = {victim_ff, iss_ff[SEM_BITS-1:0]};
         default:        ram_req.raddr = {pidx_ff, sidx_ff};
      endcase

      if (sweep_rd && iss_more) begin
         rd_v_in = 1'b1;
         iss_in  = iss_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               action_in = action;
               pidx_in   = PROC_BITS'(proc_slot);
               sidx_in   = SEM_BITS'(sem_slot);
               pok_in    = int'(proc_slot) < MAX_PROCS;
               sok_in    = int'(sem_slot) < MAX_SEMS;
               init_in   = sem_initial;
               id_in     = proc_id;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_in   = '0;
            state_in = ST_DONE;
            iss_in   = '0;
            case (action_ff)
               ACT_SEM_CREATE: begin
                  if (sok_ff) begin
                     svalid_in[sidx_ff] = 1'b1;
                     avail_in[sidx_ff]  = sat_signed(SUM_BITS'(init_ff));
                     state_in           = ST_CLR_COL;
                  end
               end
               ACT_INSTANT_GRANT, ACT_WAIT_GRANT, ACT_REQUEST, ACT_RELEASE: begin
                  if (both) begin
                     state_in = ST_RMW;
                  end
               end
               ACT_SEM_DESTROY: begin
                  if (sok_ff) begin
                     svalid_in[sidx_ff] = 1'b0;
                  end
               end
               ACT_PROC_CREATE: begin
                  if (pok_ff) begin
                     pvalid_in[pidx_ff] = 1'b1;
                     ident_in[pidx_ff]  = id_ff;
                     state_in           = ST_CLR_ROW;
                  end
               end
               ACT_PROC_TERM: begin
                  if (pok_ff) begin
                     pvalid_in[pidx_ff] = 1'b0;
                  end
               end
               ACT_DETECT: begin
                  for (int i = 0; i < MAX_SEMS; i++) begin
                     work_in[i] = WORK_BITS'(avail_ff[i]);
                  end
                  done_in  = '1;
                  state_in = ST_INIT;
               end
               default: begin
               end
            endcase
         end
         ST_RMW: begin
            case (action_ff)
               ACT_INSTANT_GRANT: begin
                  avail_in[sidx_ff] = sat_signed(a_x - 1);
                  held_n            = sat_unsigned(h_x + 1);
               end
               ACT_WAIT_GRANT: begin
                  avail_in[sidx_ff] = sat_signed(a_x - 1);
                  wanted_n          = sat_unsigned(w_x - 1);
                  held_n            = sat_unsigned(h_x + 1);
               end
               ACT_REQUEST: begin
                  wanted_n = sat_unsigned(w_x + 1);
               end
               ACT_RELEASE: begin
                  avail_in[sidx_ff] = sat_signed(a_x + 1);
                  held_n            = sat_unsigned(h_x - 1);
               end
               default: begin
               end
            endcase
            ram_req.we    = 1'b1;
            ram_req.wdata = {held_n, wanted_n};
            state_in      = ST_DONE;
         end
         ST_CLR_COL: begin
            if (iss_more) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = {iss_ff[PROC_BITS-1:0], sidx_ff};
               iss_in        = iss_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CLR_ROW: begin
            if (iss_more) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = {pidx_ff, iss_ff[SEM_BITS-1:0]};
               iss_in        = iss_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INIT: begin
            if (rd_v_ff && (int'(d_p) < MAX_PROCS) && (int'(d_s) < MAX_SEMS)) begin
               if (svalid_ff[d_s] && (held != '0)) begin
                  done_in[d_p] = 1'b0;
               end
            end
            if (sweep_end) begin
               cur_p_in   = '0;
               changed_in = 1'b0;
               state_in   = ST_PASS;
            end
         end
         ST_PASS: begin
            if (int'(cur_p_ff) == MAX_PROCS) begin
               cur_p_in = '0;
               if (changed_ff) begin
                  changed_in = 1'b0;
               end else begin
                  found_in  = 1'b0;
                  victim_in = '0;
                  state_in  = ST_VSCAN;
               end
            end else if (!pvalid_ff[cp] || done_ff[cp]) begin
               cur_p_in = cur_p_ff + 1'b1;
            end else begin
               fits_in  = 1'b1;
               iss_in   = '0;
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (rd_v_ff && svalid_ff[d_s] &&
                ($signed(WORK_BITS'(wanted)) > work_ff[d_s])) begin
               fits_in = 1'b0;
            end
            if (sweep_end) begin
               iss_in = '0;
               if (fits_ff) begin
                  state_in = ST_ADD;
               end else begin
                  cur_p_in = cur_p_ff + 1'b1;
                  state_in = ST_PASS;
               end
            end
         end
         ST_ADD: begin
            if (rd_v_ff && svalid_ff[d_s]) begin
               work_in[d_s] = work_ff[d_s] + $signed(WORK_BITS'(held));
            end
            if (sweep_end) begin
               done_in[cp] = 1'b1;
               changed_in  = 1'b1;
               cur_p_in    = cur_p_ff + 1'b1;
               state_in    = ST_PASS;
            end
         end
         ST_VSCAN: begin
            if (int'(cur_p_ff) == MAX_PROCS) begin
               iss_in   = '0;
               state_in = found_ff ? ST_FREE : ST_DONE;
            end else begin
               if (pvalid_ff[cp] && !done_ff[cp]) begin
                  if (!found_ff || (ident_ff[victim_ff] <= ident_ff[cp])) begin
                     victim_in = cp;
                  end
                  found_in = 1'b1;
               end
               cur_p_in = cur_p_ff + 1'b1;
            end
         end
         ST_FREE: begin
            if (rd_v_ff && svalid_ff[d_s]) begin
               avail_in[d_s] = sat_signed(SUM_BITS'(avail_ff[d_s]) + h_x);
               ram_req.we    = 1'b1;
               ram_req.waddr = {victim_ff, d_s};
            end
            if (sweep_end) begin
               pvalid_in[victim_ff] = 1'b0;
               res_in.found         = 1'b1;
               res_in.slot          = SLOT_BITS'(victim_ff);
               res_in.id            = ident_ff[victim_ff];
               state_in             = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pvalid_ff <= '0;
         svalid_ff <= '0;
         rd_v_ff   <= 1'b0;
         for (int i = 0; i < MAX_SEMS; i++) begin
            avail_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         pvalid_ff <= pvalid_in;
         svalid_ff <= svalid_in;
         rd_v_ff   <= rd_v_in;
         avail_ff  <= avail_in;
      end
      action_ff  <= action_in;
      pidx_ff    <= pidx_in;
      sidx_ff    <= sidx_in;
      pok_ff     <= pok_in;
      sok_ff     <= sok_in;
      init_ff    <= init_in;
      id_ff      <= id_in;
      work_ff    <= work_in;
      ident_ff   <= ident_in;
      done_ff    <= done_in;
      iss_ff     <= iss_in;
      rd_idx_ff  <= rd_idx_in;
      cur_p_ff   <= cur_p_in;
      changed_ff <= changed_in;
      fits_ff    <= fits_in;
      found_ff   <= found_in;
      victim_ff  <= victim_in;
      res_ff     <= res_in;
   end

endmodule

// ===== rtl/core/rdd_checker.sv =====
// Port-level checks for resource_deadlock_detector, bound to the top level.
// No dependencies.
module rdd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [3:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous beat in progress");

   a_clean_no_deadlock: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 24'd0)
      else $error("non-deadlock response carries victim data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind resource_deadlock_detector rdd_checker u_rdd_checker (.*);
